@@ rtl/core/mlfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared types and constants of the three-level feedback queue scheduler:
// field widths, opcodes, result status codes, register indexes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mlfs_pkg;

   // default sizing
   localparam int MAX_PROCS_DEF   = 4;
   localparam int BURST_WIDTH_DEF = 16;

   // scheduling structure
   localparam int NUM_LEVELS      = 3;
   localparam int BURSTS_PER_PROC = 3;
   localparam int LAST_BURST      = 2;

   // port field widths
   localparam int OPCODE_W    = 1;
   localparam int SLOT_ID_W   = 2;
   localparam int IN_BURST_W  = 16;
   localparam int STATUS_W    = 3;
   localparam int LEVEL_W     = 2;
   localparam int REMAIN_W    = 16;
   localparam int ACTIVE_W    = 3;
   localparam int QUANTUM_W   = 8;
   localparam int CSR_INDEX_W = 2;

   // burst index held beside the bursts of a slot
   localparam int IDX_W = 2;

   // quantum per level after reset, top level first
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET [NUM_LEVELS] = '{8'd1, 8'd2, 8'd4};

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_RUN  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM_L1 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM_L2 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM_L3 = 2'd2;

   // queue level numbering inside the core (0 is the highest priority)
   localparam logic [LEVEL_W-1:0] LVL_TOP    = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_BOTTOM = 2'd2;

   // result status
   typedef enum logic [STATUS_W-1:0] {
      ST_LOADED          = 3'd0,
      ST_SLOT_BUSY       = 3'd1,
      ST_IDLE            = 3'd2,
      ST_QUANTUM_EXPIRED = 3'd3,
      ST_BURST_DONE      = 3'd4,
      ST_PROC_DONE       = 3'd5
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic idle;      // controller waiting for a beat, queue head read enabled
      logic accept;    // request beat taken this cycle
      logic burst_rd;  // read the burst row of the popped slot
      logic commit;    // update state and load the result register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_run;       // offered request is a run
      logic queues_empty;  // no process waiting at any level
      logic out_free;      // result register can take a new beat
   } dp_status_type;

endpackage

@@ rtl/core/mlfs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module mlfs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mlfs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_ctrl
// Sequencer of the scheduler: takes a request beat, runs the burst fetch for
// a run request that finds a process queued and commits the update once the
// result register is free.
module mlfs_ctrl
   import mlfs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FETCH = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.idle   = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               // a run with something queued needs the burst row first
               if (stat.req_run && !stat.queues_empty) begin
                  state_in = S_FETCH;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_FETCH: begin
            cmd.burst_rd = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/mlfs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_datapath
// Process and queue state of the scheduler: quantum registers, slot valid
// bits, per-level FIFO pointers, burst row RAM, queue RAM and the result
// register.
// ----------------------------------------------------------------------------
module mlfs_datapath
   import mlfs_pkg::*;
#(
   parameter int MAX_PROCS   = MAX_PROCS_DEF,
   parameter int BURST_WIDTH = BURST_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          stat,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic [SLOT_ID_W-1:0]   req_slot_id,
   input  logic [IN_BURST_W-1:0]  req_first_burst,
   input  logic [IN_BURST_W-1:0]  req_second_burst,
   input  logic [IN_BURST_W-1:0]  req_third_burst,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_ID_W-1:0]   rsp_served_slot,
   output logic [LEVEL_W-1:0]     rsp_served_level,
   output logic [LEVEL_W-1:0]     rsp_new_level,
   output logic [REMAIN_W-1:0]    rsp_remaining,
   output logic [ACTIVE_W-1:0]    rsp_active_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [QUANTUM_W-1:0]   csr_data
);

   localparam int SLOT_W  = $clog2(MAX_PROCS);
   localparam int CNT_W   = $clog2(MAX_PROCS + 1);
   localparam int QDEPTH  = NUM_LEVELS * MAX_PROCS;
   localparam int QADDR_W = $clog2(QDEPTH);
   localparam int ROW_W   = BURSTS_PER_PROC * BURST_WIDTH + IDX_W;
   localparam int CMP_W   = (BURST_WIDTH > QUANTUM_W) ? BURST_WIDTH : QUANTUM_W;

   // configuration
   logic [QUANTUM_W-1:0]   quantum_ff [NUM_LEVELS];
   logic [QUANTUM_W-1:0]   quantum_in [NUM_LEVELS];

   // captured request
   logic                   req_run_ff, req_run_in;
   logic [SLOT_ID_W-1:0]   req_slot_ff, req_slot_in;
   logic [BURST_WIDTH-1:0] req_burst_ff [BURSTS_PER_PROC];
   logic [BURST_WIDTH-1:0] req_burst_in [BURSTS_PER_PROC];

   // slot and queue state
   logic [MAX_PROCS-1:0]   slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]       active_ff, active_in;
   logic [SLOT_W-1:0]      q_head_ff [NUM_LEVELS];
   logic [SLOT_W-1:0]      q_head_in [NUM_LEVELS];
   logic [CNT_W-1:0]       q_count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]       q_count_in [NUM_LEVELS];

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [SLOT_ID_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [LEVEL_W-1:0]     rsp_served_ff, rsp_served_in;
   logic [LEVEL_W-1:0]     rsp_new_ff, rsp_new_in;
   logic [REMAIN_W-1:0]    rsp_rem_ff, rsp_rem_in;
   logic [ACTIVE_W-1:0]    rsp_active_ff, rsp_active_in;

   // per-level queue helpers
   logic [SLOT_W:0]        tail_sum [NUM_LEVELS];
   logic [SLOT_W-1:0]      tail_pos [NUM_LEVELS];
   logic [SLOT_W-1:0]      head_inc [NUM_LEVELS];
   logic [NUM_LEVELS-1:0]  nonempty;
   logic [NUM_LEVELS-1:0]  not_full;
   logic [LEVEL_W-1:0]     sel_lvl;

   // RAM ports
   logic [SLOT_W-1:0]      q_rdata;
   logic [QADDR_W-1:0]     q_rd_addr, q_wr_addr;
   logic                   q_we;
   logic [ROW_W-1:0]       b_rdata, b_wdata;
   logic                   b_we;

   // item evaluation
   logic [SLOT_W-1:0]      cur_slot;
   logic                   slot_in_range;
   logic                   load_ok;
   logic [IDX_W-1:0]       idx_raw, bi;
   logic [BURST_WIDTH-1:0] cur_burst, rem;
   logic [CMP_W-1:0]       b_ext, q_ext;
   logic [ROW_W-1:0]       upd_row;
   logic                   do_pop, do_push, do_load, do_retire, row_we;
   logic [LEVEL_W-1:0]     push_lvl;
   status_type             status;

   // configuration write port, always ready; writes come only when idle is a rule for the user, not enforced here
   assign csr_ready = 1'b1;

   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         quantum_in[l] = quantum_ff[l];
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_QUANTUM_L1: quantum_in[0] = csr_data;
            CSR_QUANTUM_L2: quantum_in[1] = csr_data;
            CSR_QUANTUM_L3: quantum_in[2] = csr_data;
            default: ;
         endcase
      end
   end

   // request capture
   always_comb begin
      req_run_in  = req_run_ff;
      req_slot_in = req_slot_ff;
      for (int k = 0; k < BURSTS_PER_PROC; k++) begin
         req_burst_in[k] = req_burst_ff[k];
      end
      if (cmd.accept) begin
         req_run_in      = (req_opcode == OP_RUN);
         req_slot_in     = req_slot_id;
         req_burst_in[0] = BURST_WIDTH'(req_first_burst);
         req_burst_in[1] = BURST_WIDTH'(req_second_burst);
         req_burst_in[2] = BURST_WIDTH'(req_third_burst);
      end
   end

   // per-level fifo pointers: tail position, next head, occupancy flags
   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         tail_sum[l] = (SLOT_W + 1)'(q_head_ff[l]) + (SLOT_W + 1)'(q_count_ff[l]);
         if (tail_sum[l] >= (SLOT_W + 1)'(MAX_PROCS)) begin
            tail_pos[l] = SLOT_W'(tail_sum[l] - (SLOT_W + 1)'(MAX_PROCS));
         end else begin
            tail_pos[l] = SLOT_W'(tail_sum[l]);
         end
         if (q_head_ff[l] == SLOT_W'(MAX_PROCS - 1)) begin
            head_inc[l] = '0;
         end else begin
            head_inc[l] = q_head_ff[l] + SLOT_W'(1);
         end
         nonempty[l] = (q_count_ff[l] != '0);
         not_full[l] = (q_count_ff[l] < CNT_W'(MAX_PROCS));
      end
   end

   // highest non-empty level
   always_comb begin
      sel_lvl = LVL_BOTTOM;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (nonempty[l]) begin
            sel_lvl = LEVEL_W'(l);
         end
      end
   end

   assign stat.req_run      = (req_opcode == OP_RUN);
   assign stat.queues_empty = ~|nonempty;
   assign stat.out_free     = !rsp_valid_ff || !rsp_stall;

   // queue RAM: head of the selected level is read while waiting for a beat
   assign q_rd_addr = QADDR_W'(sel_lvl) * QADDR_W'(MAX_PROCS) + QADDR_W'(q_head_ff[sel_lvl]);
   assign q_wr_addr = QADDR_W'(push_lvl) * QADDR_W'(MAX_PROCS) + QADDR_W'(tail_pos[push_lvl]);
   assign q_we      = cmd.commit && do_push;

   mlfs_ram #(
      .WIDTH  (SLOT_W),
      .DEPTH  (QDEPTH),
      .ADDR_W (QADDR_W)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_wr_addr),
      .wr_data (cur_slot),
      .rd_en   (cmd.idle),
      .rd_addr (q_rd_addr),
      .rd_data (q_rdata)
   );

   // burst row RAM: three bursts and the burst index of each slot
   assign cur_slot = req_run_ff ? q_rdata : SLOT_W'(req_slot_ff);
   assign b_we     = cmd.commit && row_we;

   mlfs_ram #(
      .WIDTH  (ROW_W),
      .DEPTH  (MAX_PROCS),
      .ADDR_W (SLOT_W)
   ) u_burst_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (cur_slot),
      .wr_data (b_wdata),
      .rd_en   (cmd.burst_rd),
      .rd_addr (cur_slot),
      .rd_data (b_rdata)
   );

   // quantum subtraction on the current burst, saturating at zero
   assign slot_in_range = (32'(req_slot_ff) < 32'(MAX_PROCS));
   assign load_ok       = slot_in_range && !slot_valid_ff[SLOT_W'(req_slot_ff)];
   assign idx_raw       = b_rdata[ROW_W-1 -: IDX_W];
   assign bi            = (idx_raw > IDX_W'(LAST_BURST)) ? IDX_W'(LAST_BURST) : idx_raw;
   assign cur_burst     = b_rdata[32'(bi) * BURST_WIDTH +: BURST_WIDTH];
   assign b_ext         = CMP_W'(cur_burst);
   assign q_ext         = CMP_W'(quantum_ff[sel_lvl]);
   assign rem           = (b_ext > q_ext) ? BURST_WIDTH'(b_ext - q_ext) : '0;

   // decide the outcome of the item and the result fields
   always_comb begin
      do_pop        = 1'b0;
      do_push       = 1'b0;
      do_load       = 1'b0;
      do_retire     = 1'b0;
      row_we        = 1'b0;
      push_lvl      = LVL_TOP;
      status        = ST_IDLE;
      rsp_slot_in   = '0;
      rsp_served_in = LEVEL_W'(1);
      rsp_new_in    = LEVEL_W'(1);
      rsp_rem_in    = '0;
      upd_row       = b_rdata;
      upd_row[32'(bi) * BURST_WIDTH +: BURST_WIDTH] = rem;
      b_wdata       = upd_row;
      if (!req_run_ff) begin
         rsp_slot_in = req_slot_ff;
         if (load_ok) begin
            status  = ST_LOADED;
            do_load = 1'b1;
            row_we  = 1'b1;
            do_push = not_full[LVL_TOP];
            b_wdata = '0;
            for (int k = 0; k < BURSTS_PER_PROC; k++) begin
               b_wdata[k * BURST_WIDTH +: BURST_WIDTH] = req_burst_ff[k];
            end
            rsp_rem_in = REMAIN_W'(req_burst_ff[0]);
         end else begin
            status = ST_SLOT_BUSY;
         end
      end else if (!stat.queues_empty) begin
         do_pop        = 1'b1;
         row_we        = 1'b1;
         rsp_slot_in   = SLOT_ID_W'(q_rdata);
         rsp_served_in = sel_lvl + LEVEL_W'(1);
         rsp_rem_in    = REMAIN_W'(rem);
         push_lvl      = sel_lvl;
         if (rem != '0) begin
            // quantum used up: drop one level unless already at the bottom
            status = ST_QUANTUM_EXPIRED;
            if (sel_lvl != LVL_BOTTOM) begin
               push_lvl = sel_lvl + LEVEL_W'(1);
            end
            do_push = (push_lvl == sel_lvl) || not_full[push_lvl];
         end else if (bi >= IDX_W'(LAST_BURST)) begin
            // last burst finished: free the slot
            status    = ST_PROC_DONE;
            do_retire = 1'b1;
         end else begin
            // burst finished: next burst, rise one level unless already at the top
            status = ST_BURST_DONE;
            upd_row[ROW_W-1 -: IDX_W] = bi + IDX_W'(1);
            b_wdata = upd_row;
            if (sel_lvl != LVL_TOP) begin
               push_lvl = sel_lvl - LEVEL_W'(1);
            end
            do_push = (push_lvl == sel_lvl) || not_full[push_lvl];
         end
         rsp_new_in = push_lvl + LEVEL_W'(1);
      end
   end

   // queue pointer, slot valid and active count updates
   always_comb begin
      slot_valid_in = slot_valid_ff;
      active_in     = active_ff;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         q_head_in[l]  = q_head_ff[l];
         q_count_in[l] = q_count_ff[l];
         if (cmd.commit) begin
            if (do_pop && (sel_lvl == LEVEL_W'(l))) begin
               q_head_in[l] = head_inc[l];
               if (!(do_push && (push_lvl == LEVEL_W'(l)))) begin
                  q_count_in[l] = q_count_ff[l] - CNT_W'(1);
               end
            end else if (do_push && (push_lvl == LEVEL_W'(l))) begin
               q_count_in[l] = q_count_ff[l] + CNT_W'(1);
            end
         end
      end
      if (cmd.commit && do_load) begin
         slot_valid_in[cur_slot] = 1'b1;
         active_in               = active_ff + CNT_W'(1);
      end
      if (cmd.commit && do_retire) begin
         slot_valid_in[cur_slot] = 1'b0;
         active_in               = active_ff - CNT_W'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_active_in = rsp_active_ff;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_active_in = ACTIVE_W'(active_in);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         active_ff     <= '0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            quantum_ff[l] <= QUANTUM_RESET[l];
            q_head_ff[l]  <= '0;
            q_count_ff[l] <= '0;
         end
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         slot_valid_ff <= slot_valid_in;
         active_ff     <= active_in;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            quantum_ff[l] <= quantum_in[l];
            q_head_ff[l]  <= q_head_in[l];
            q_count_ff[l] <= q_count_in[l];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_run_ff    <= req_run_in;
      req_slot_ff   <= req_slot_in;
      for (int k = 0; k < BURSTS_PER_PROC; k++) begin
         req_burst_ff[k] <= req_burst_in[k];
      end
      rsp_status_ff <= rsp_status_in;
      rsp_active_ff <= rsp_active_in;
      if (cmd.commit) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_served_ff <= rsp_served_in;
         rsp_new_ff    <= rsp_new_in;
         rsp_rem_ff    <= rsp_rem_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_served_slot  = rsp_slot_ff;
   assign rsp_served_level = rsp_served_ff;
   assign rsp_new_level    = rsp_new_ff;
   assign rsp_remaining    = rsp_rem_ff;
   assign rsp_active_count = rsp_active_ff;

endmodule

@@ rtl/core/multilevel_feedback_scheduler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core
// Usage:
//   req_*  : request beats (load a process into a slot, or run one quantum),
//            taken when req_valid is high and req_stall low.
//   rsp_*  : one result beat per request, taken when rsp_valid is high and
//            rsp_stall low; the beat holds steady while stalled.
//   csr_*  : quantum registers of levels 1 to 3, indexes 0 to 2, written
//            when csr_valid and csr_ready are high; only while idle.
// Sequence: a load, or a run with every queue empty, is committed to the
// result register once it is free; a run that serves a process first takes
// the registered read of the slot's burst row.
// No new request is taken until the last one is committed, as the queue
// RAM read, burst RAM read and commit are done one after the other.
// A new request is taken while the last result still waits at rsp_*; if
// the receiver keeps stalling, the commit of the next item waits for it.
// Reset: synchronous, active high; quanta return to 1, 2 and 4, all slots
// are free and all queues empty. The RAMs are not cleared.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_core
   import mlfs_pkg::*;
#(
   parameter int MAX_PROCS   = MAX_PROCS_DEF,
   parameter int BURST_WIDTH = BURST_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic [SLOT_ID_W-1:0]   req_slot_id,
   input  logic [IN_BURST_W-1:0]  req_first_burst,
   input  logic [IN_BURST_W-1:0]  req_second_burst,
   input  logic [IN_BURST_W-1:0]  req_third_burst,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_ID_W-1:0]   rsp_served_slot,
   output logic [LEVEL_W-1:0]     rsp_served_level,
   output logic [LEVEL_W-1:0]     rsp_new_level,
   output logic [REMAIN_W-1:0]    rsp_remaining,
   output logic [ACTIVE_W-1:0]    rsp_active_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [QUANTUM_W-1:0]   csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // sequencer
   mlfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // state and result datapath
   mlfs_datapath #(
      .MAX_PROCS   (MAX_PROCS),
      .BURST_WIDTH (BURST_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_slot_id      (req_slot_id),
      .req_first_burst  (req_first_burst),
      .req_second_burst (req_second_burst),
      .req_third_burst  (req_third_burst),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_served_slot  (rsp_served_slot),
      .rsp_served_level (rsp_served_level),
      .rsp_new_level    (rsp_new_level),
      .rsp_remaining    (rsp_remaining),
      .rsp_active_count (rsp_active_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

`ifndef SYNTHESIS
   // the block is busy in the cycle after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken back to back");

   // every commit presents a result beat
   a_commit_gives_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without result beat");

   // commit only with room in the result register
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.out_free)
      else $error("result overwritten while stalled");

   // status code stays within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_PROC_DONE))
      else $error("undefined status code");
`endif

endmodule
